[src/wheel_speed_pid_unit_defines.svh]
// Assertion macros used by the wheel speed loop checker.
`ifndef WHEEL_SPEED_PID_UNIT_DEFINES_SVH
`define WHEEL_SPEED_PID_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define WSP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define WSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/wsp_pkg.sv]
// Shared constants, types and helper functions of the wheel speed loop.
package wsp_pkg;

  localparam int FRAC_BITS  = 8;
  localparam int PWM_MAX    = 255;
  localparam int GAIN_FRAC  = 12;
  localparam int DECAY_FRAC = 8;
  localparam int DECAY_ONE  = 2 ** DECAY_FRAC;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int GAIN_W     = 16;
  localparam int LIM_W      = 20;
  localparam int FAC_W      = 9;

  localparam int DELTA_W = 16;
  localparam int TGT_W   = 19;
  localparam int MS_W    = 16;
  localparam int S24_W   = 24;
  localparam int DUTY_W  = 8;
  localparam int DIFF_W  = S24_W + 1;
  localparam int DERIV_W = 35;

  localparam int ACC_W   = 56;
  localparam int CHUNK_W = 18;
  localparam int OPA_W   = 2 * CHUNK_W;
  localparam int OPB_W   = 17;
  localparam int PROD_W  = CHUNK_W + OPB_W;

  localparam int DIVD_W         = 40;
  localparam int DVS_W          = 32;
  localparam int QUO_W          = DIVD_W + 1;
  localparam int DIV_RADIX_BITS = 2;
  localparam int DIV_STEPS      = DIVD_W / DIV_RADIX_BITS;
  localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

  localparam int MS_PER_S = 1000;
  localparam logic [OPA_W-1:0] SPEED_SCALE = OPA_W'(longint'(60000) << FRAC_BITS);

  localparam longint S24_MAX = 8388607;
  localparam longint S24_MIN = -8388608;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P    = 3'd0,
    REG_GAIN_I    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_INT_LIMIT = 3'd3,
    REG_DECAY_BND = 3'd4,
    REG_DECAY_FAC = 3'd5,
    REG_PPR       = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    A_PPR, A_SCALE, A_ERR, A_INTEG, A_DIFF, A_DERIV
  } a_sel_t;

  typedef enum logic [2:0] {
    B_MS, B_DELTA, B_FAC, B_K1000, B_GP, B_GI, B_GD
  } b_sel_t;

  typedef enum logic [1:0] {
    DVS_DEN, DVS_K1000, DVS_MS
  } dvs_sel_t;

  typedef enum logic [5:0] {
    S_IDLE, S_DEN0, S_DEN1, S_DEN2, S_NUM1, S_NUM2, S_NUM3, S_DIV_SPD, S_SPD,
    S_IN0, S_IN1, S_IN2, S_IN3, S_DIV_IN, S_INT,
    S_DEC0, S_DEC1, S_DEC2, S_DEC3,
    S_DR0, S_DR1, S_DR2, S_DR3, S_DIV_DR, S_DER,
    S_SUM0, S_SUM1, S_SUM2, S_SUM3, S_SUM4, S_SUM5, S_SUM6, S_FIN
  } state_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    a_sel_t   a_sel;
    b_sel_t   b_sel;
    logic     chunk;
    logic     acc_clr;
    logic     den_ld;
    logic     div_start;
    dvs_sel_t dvs_sel;
    logic     spd_ld;
    logic     integ_ld;
    logic     decay_ld;
    logic     deriv_ld;
    logic     fin_ld;
  } wsp_cmd_t;

  typedef struct packed {
    logic div_done;
  } wsp_status_t;

  function automatic logic signed [S24_W-1:0] sat_s24(input logic signed [ACC_W-1:0] v);
    logic signed [S24_W-1:0] r;
    if (v > S24_MAX) r = S24_W'(S24_MAX);
    else if (v < S24_MIN) r = S24_W'(S24_MIN);
    else r = v[S24_W-1:0];
    return r;
  endfunction

  // Arithmetic right shift that rounds toward zero.
  function automatic logic signed [ACC_W-1:0] shr_trunc(input logic signed [ACC_W-1:0] v,
                                                        input int sh);
    logic signed [ACC_W-1:0] bias;
    logic signed [ACC_W-1:0] t;
    bias = signed'((ACC_W'(1) << sh) - ACC_W'(1));
    t = v[ACC_W-1] ? (v + bias) : v;
    return t >>> sh;
  endfunction

endpackage

[src/wheel_speed_pid_unit.sv]
// Top level of the single-wheel speed loop: PID with integral clamp and decay.
//
// Channels: a configuration write channel (cfg_valid/cfg_ready, cfg_index,
// cfg_data) that is always ready and is meant to be used while no tick is in
// flight; an input channel carrying one control tick per beat (count_change,
// target_speed, elapsed_ms); and an output channel carrying one result beat
// per tick (measured_speed, control_value, drive_forward, pwm_duty).
// Three divider passes (two quotient bits per cycle) dominate the time from an
// accepted input beat to out_valid, and the rest is the shared 18x17 multiplier
// sequence of the controller. A new input beat is taken as soon as the previous
// tick has written its result into the output register.
// Reset clears the integral and the last error, loads the default gains and
// drops out_valid. When the receiver stalls, the result holds in the output
// register while the next tick is accepted and computed; that tick then waits
// at its final step until the held beat is taken.
module wheel_speed_pid_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wsp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wsp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [wsp_pkg::DELTA_W-1:0] count_change,
  input  logic signed [wsp_pkg::TGT_W-1:0]   target_speed,
  input  logic [wsp_pkg::MS_W-1:0]           elapsed_ms,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [wsp_pkg::S24_W-1:0]   measured_speed,
  output logic signed [wsp_pkg::S24_W-1:0]   control_value,
  output logic                               drive_forward,
  output logic [wsp_pkg::DUTY_W-1:0]         pwm_duty
);
  import wsp_pkg::*;

  wsp_cmd_t    cmd;
  wsp_status_t status;

  assign cfg_ready = 1'b1;

  wsp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  wsp_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .count_change   (count_change),
    .target_speed   (target_speed),
    .elapsed_ms     (elapsed_ms),
    .measured_speed (measured_speed),
    .control_value  (control_value),
    .drive_forward  (drive_forward),
    .pwm_duty       (pwm_duty)
  );

endmodule

[src/wsp_div.sv]
// Restoring unsigned divider that retires two quotient bits per cycle.
module wsp_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [wsp_pkg::DIVD_W-1:0] dividend,
  input  logic [wsp_pkg::DVS_W-1:0]  divisor,
  output logic                       done,
  output logic [wsp_pkg::DIVD_W-1:0] quotient
);
  import wsp_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DVS_W:0]       rem;
  logic [DVS_W:0]       rem_next;
  logic [DIVD_W-1:0]    quo_next;
  logic [DVS_W-1:0]     dvs;

  always_comb begin
    rem_next = rem;
    quo_next = quotient;
    for (int i = 0; i < DIV_RADIX_BITS; i++) begin
      rem_next = {rem_next[DVS_W-1:0], quo_next[DIVD_W-1]};
      quo_next = {quo_next[DIVD_W-2:0], 1'b0};
      if (rem_next >= {1'b0, dvs}) begin
        rem_next    = rem_next - {1'b0, dvs};
        quo_next[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      dvs      <= divisor;
    end else if (busy) begin
      rem      <= rem_next;
      quotient <= quo_next;
    end
  end

endmodule

[src/wsp_datapath.sv]
// Datapath: configuration registers, shared multiplier, accumulator, divider and loop state.
module wsp_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  wsp_pkg::wsp_cmd_t                   cmd,
  output wsp_pkg::wsp_status_t                status,
  input  logic                                cfg_valid,
  input  logic [wsp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wsp_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic signed [wsp_pkg::DELTA_W-1:0]  count_change,
  input  logic signed [wsp_pkg::TGT_W-1:0]    target_speed,
  input  logic [wsp_pkg::MS_W-1:0]            elapsed_ms,
  output logic signed [wsp_pkg::S24_W-1:0]    measured_speed,
  output logic signed [wsp_pkg::S24_W-1:0]    control_value,
  output logic                                drive_forward,
  output logic [wsp_pkg::DUTY_W-1:0]          pwm_duty
);
  import wsp_pkg::*;

  logic [GAIN_W-1:0] gain_p, gain_i, gain_d, decay_band, pulses_per_rev;
  logic [LIM_W-1:0]  integral_limit;
  logic [FAC_W-1:0]  decay_factor;

  logic signed [DELTA_W-1:0] delta;
  logic signed [TGT_W-1:0]   target;
  logic [MS_W-1:0]           ms;
  logic [DVS_W-1:0]          den;
  logic signed [S24_W-1:0]   speed, err, integ, integral_sum, last_error;
  logic signed [DERIV_W-1:0] deriv;

  logic signed [ACC_W-1:0] acc;
  logic [PROD_W-1:0]       prod;
  logic                    prod_neg, prod_hi, prod_vld;
  logic                    div_neg;

  logic [GAIN_W-1:0]         ppr_eff;
  logic [FAC_W-1:0]          fac_eff;
  logic [S24_W-1:0]          err_mag, integ_mag;
  logic signed [DIFF_W-1:0]  diff;
  logic [DIFF_W-1:0]         diff_mag;
  logic [DERIV_W-1:0]        deriv_mag;
  logic [DELTA_W-1:0]        delta_mag;
  logic [OPA_W-1:0]          op_a;
  logic [CHUNK_W-1:0]        chunk_a;
  logic [OPB_W-1:0]          op_b;
  logic                      a_neg, b_neg;
  logic signed [ACC_W-1:0]   prod_ext;
  logic [ACC_W-1:0]          acc_mag;
  logic [DVS_W-1:0]          dvs_mux;
  logic                      div_done;
  logic [DIVD_W-1:0]         quo;
  logic signed [QUO_W-1:0]   q_s;
  logic signed [S24_W-1:0]   spd_w;
  logic signed [S24_W:0]     err_diff;
  logic signed [ACC_W-1:0]   isum, lim_s, integ_w;
  logic signed [S24_W-1:0]   ctrl_w;
  logic [S24_W-1:0]          ctrl_mag, ctrl_int;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p         <= GAIN_W'(1638);
      gain_i         <= GAIN_W'(4096);
      gain_d         <= GAIN_W'(328);
      integral_limit <= LIM_W'(25600);
      decay_band     <= GAIN_W'(256);
      decay_factor   <= FAC_W'(230);
      pulses_per_rev <= GAIN_W'(1612);
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_GAIN_P:    gain_p         <= cfg_data[GAIN_W-1:0];
        REG_GAIN_I:    gain_i         <= cfg_data[GAIN_W-1:0];
        REG_GAIN_D:    gain_d         <= cfg_data[GAIN_W-1:0];
        REG_INT_LIMIT: integral_limit <= cfg_data[LIM_W-1:0];
        REG_DECAY_BND: decay_band     <= cfg_data[GAIN_W-1:0];
        REG_DECAY_FAC: decay_factor   <= cfg_data[FAC_W-1:0];
        REG_PPR:       pulses_per_rev <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign ppr_eff   = (pulses_per_rev == '0) ? GAIN_W'(1) : pulses_per_rev;
  assign fac_eff   = (decay_factor > FAC_W'(DECAY_ONE)) ? FAC_W'(DECAY_ONE) : decay_factor;
  assign err_mag   = err[S24_W-1] ? -err : err;
  assign integ_mag = integ[S24_W-1] ? -integ : integ;
  assign diff      = DIFF_W'(err) - DIFF_W'(last_error);
  assign diff_mag  = diff[DIFF_W-1] ? -diff : diff;
  assign deriv_mag = deriv[DERIV_W-1] ? -deriv : deriv;
  assign delta_mag = delta[DELTA_W-1] ? -delta : delta;

  // Operand selection for the shared multiplier, in sign and magnitude form.
  always_comb begin
    a_neg = 1'b0;
    case (cmd.a_sel)
      A_PPR:   op_a = OPA_W'(ppr_eff);
      A_SCALE: op_a = SPEED_SCALE;
      A_ERR: begin
        op_a  = OPA_W'(err_mag);
        a_neg = err[S24_W-1];
      end
      A_INTEG: begin
        op_a  = OPA_W'(integ_mag);
        a_neg = integ[S24_W-1];
      end
      A_DIFF: begin
        op_a  = OPA_W'(diff_mag);
        a_neg = diff[DIFF_W-1];
      end
      A_DERIV: begin
        op_a  = OPA_W'(deriv_mag);
        a_neg = deriv[DERIV_W-1];
      end
      default: op_a = '0;
    endcase
  end

  always_comb begin
    b_neg = 1'b0;
    case (cmd.b_sel)
      B_MS:    op_b = OPB_W'(ms);
      B_DELTA: begin
        op_b  = OPB_W'(delta_mag);
        b_neg = delta[DELTA_W-1];
      end
      B_FAC:   op_b = OPB_W'(fac_eff);
      B_K1000: op_b = OPB_W'(MS_PER_S);
      B_GP:    op_b = OPB_W'(gain_p);
      B_GI:    op_b = OPB_W'(gain_i);
      B_GD:    op_b = OPB_W'(gain_d);
      default: op_b = '0;
    endcase
  end

  assign chunk_a  = cmd.chunk ? op_a[OPA_W-1:CHUNK_W] : op_a[CHUNK_W-1:0];
  assign prod_ext = signed'(ACC_W'(prod) << (prod_hi ? CHUNK_W : 0));

  // Multiplier stage, then accumulation in the following cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= cmd.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod     <= PROD_W'(chunk_a) * PROD_W'(op_b);
      prod_neg <= a_neg ^ b_neg;
      prod_hi  <= cmd.chunk;
    end
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= prod_neg ? (acc - prod_ext) : (acc + prod_ext);
    end
  end

  // Divider feed: magnitude of the accumulator over the selected divisor.
  assign acc_mag = acc[ACC_W-1] ? -acc : acc;

  always_comb begin
    case (cmd.dvs_sel)
      DVS_DEN:   dvs_mux = den;
      DVS_K1000: dvs_mux = DVS_W'(MS_PER_S);
      DVS_MS:    dvs_mux = DVS_W'(ms);
      default:   dvs_mux = DVS_W'(1);
    endcase
  end

  wsp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (acc_mag[DIVD_W-1:0]),
    .divisor  (dvs_mux),
    .done     (div_done),
    .quotient (quo)
  );

  assign status.div_done = div_done;

  assign q_s      = div_neg ? -signed'({1'b0, quo}) : signed'({1'b0, quo});
  assign spd_w    = sat_s24(ACC_W'(q_s));
  assign err_diff = (S24_W+1)'(target) - (S24_W+1)'(spd_w);

  assign isum  = ACC_W'(integral_sum) + ACC_W'(q_s);
  assign lim_s = signed'(ACC_W'(integral_limit));
  always_comb begin
    if (isum > lim_s) integ_w = lim_s;
    else if (isum < -lim_s) integ_w = -lim_s;
    else integ_w = isum;
  end

  assign ctrl_w   = sat_s24(shr_trunc(acc, GAIN_FRAC));
  assign ctrl_mag = ctrl_w[S24_W-1] ? -ctrl_w : ctrl_w;
  assign ctrl_int = ctrl_mag >> FRAC_BITS;

  // Loop state is cleared to zero by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum <= '0;
      last_error   <= '0;
    end else if (cmd.fin_ld) begin
      integral_sum <= integ;
      last_error   <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      delta  <= count_change;
      target <= target_speed;
      ms     <= (elapsed_ms == '0) ? MS_W'(1) : elapsed_ms;
    end
    if (cmd.den_ld) begin
      den <= acc[DVS_W-1:0];
    end
    if (cmd.div_start) begin
      div_neg <= acc[ACC_W-1];
    end
    if (cmd.spd_ld) begin
      speed <= spd_w;
      err   <= sat_s24(ACC_W'(err_diff));
    end
    if (cmd.integ_ld) begin
      integ <= integ_w[S24_W-1:0];
    end
    if (cmd.decay_ld && (err_mag < S24_W'(decay_band))) begin
      integ <= shr_trunc(acc, DECAY_FRAC)[S24_W-1:0];
    end
    if (cmd.deriv_ld) begin
      deriv <= q_s[DERIV_W-1:0];
    end
    if (cmd.fin_ld) begin
      measured_speed <= speed;
      control_value  <= ctrl_w;
      drive_forward  <= !ctrl_w[S24_W-1] && (ctrl_w != '0);
      pwm_duty       <= (ctrl_int > S24_W'(PWM_MAX)) ? DUTY_W'(PWM_MAX)
                                                     : ctrl_int[DUTY_W-1:0];
    end
  end

endmodule

[src/wsp_ctrl.sv]
// Controller: sequences the multiplier and divider passes of one control tick.
module wsp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  wsp_pkg::wsp_status_t status,
  output wsp_pkg::wsp_cmd_t    cmd
);
  import wsp_pkg::*;

  state_t state, state_next;
  logic   fin_fire;

  assign in_ready = (state == S_IDLE);
  assign fin_fire = (state == S_FIN) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (fin_fire) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (in_valid) state_next = S_DEN0;
      S_DEN0:    state_next = S_DEN1;
      S_DEN1:    state_next = S_DEN2;
      S_DEN2:    state_next = S_NUM1;
      S_NUM1:    state_next = S_NUM2;
      S_NUM2:    state_next = S_NUM3;
      S_NUM3:    state_next = S_DIV_SPD;
      S_DIV_SPD: if (status.div_done) state_next = S_SPD;
      S_SPD:     state_next = S_IN0;
      S_IN0:     state_next = S_IN1;
      S_IN1:     state_next = S_IN2;
      S_IN2:     state_next = S_IN3;
      S_IN3:     state_next = S_DIV_IN;
      S_DIV_IN:  if (status.div_done) state_next = S_INT;
      S_INT:     state_next = S_DEC0;
      S_DEC0:    state_next = S_DEC1;
      S_DEC1:    state_next = S_DEC2;
      S_DEC2:    state_next = S_DEC3;
      S_DEC3:    state_next = S_DR0;
      S_DR0:     state_next = S_DR1;
      S_DR1:     state_next = S_DR2;
      S_DR2:     state_next = S_DR3;
      S_DR3:     state_next = S_DIV_DR;
      S_DIV_DR:  if (status.div_done) state_next = S_DER;
      S_DER:     state_next = S_SUM0;
      S_SUM0:    state_next = S_SUM1;
      S_SUM1:    state_next = S_SUM2;
      S_SUM2:    state_next = S_SUM3;
      S_SUM3:    state_next = S_SUM4;
      S_SUM4:    state_next = S_SUM5;
      S_SUM5:    state_next = S_SUM6;
      S_SUM6:    state_next = S_FIN;
      S_FIN:     if (fin_fire) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.a_sel   = A_PPR;
    cmd.b_sel   = B_MS;
    cmd.dvs_sel = DVS_DEN;
    case (state)
      S_IDLE: cmd.load = in_valid;
      S_DEN0: begin
        cmd.mul_en  = 1'b1;
        cmd.acc_clr = 1'b1;
      end
      S_DEN2: begin
        // The divisor is taken from the accumulator as the numerator starts.
        cmd.den_ld  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.acc_clr = 1'b1;
        cmd.a_sel   = A_SCALE;
        cmd.b_sel   = B_DELTA;
      end
      S_NUM1: begin
        cmd.mul_en = 1'b1;
        cmd.chunk  = 1'b1;
        cmd.a_sel  = A_SCALE;
        cmd.b_sel  = B_DELTA;
      end
      S_NUM3: cmd.div_start = 1'b1;
      S_SPD:  cmd.spd_ld = 1'b1;
      S_IN0: begin
        cmd.mul_en  = 1'b1;
        cmd.acc_clr = 1'b1;
        cmd.a_sel   = A_ERR;
      end
      S_IN1: begin
        cmd.mul_en = 1'b1;
        cmd.chunk  = 1'b1;
        cmd.a_sel  = A_ERR;
      end
      S_IN3: begin
        cmd.div_start = 1'b1;
        cmd.dvs_sel   = DVS_K1000;
      end
      S_INT: cmd.integ_ld = 1'b1;
      S_DEC0: begin
        cmd.mul_en  = 1'b1;
        cmd.acc_clr = 1'b1;
        cmd.a_sel   = A_INTEG;
        cmd.b_sel   = B_FAC;
      end
      S_DEC1: begin
        cmd.mul_en = 1'b1;
        cmd.chunk  = 1'b1;
        cmd.a_sel  = A_INTEG;
        cmd.b_sel  = B_FAC;
      end
      S_DEC3: cmd.decay_ld = 1'b1;
      S_DR0: begin
        cmd.mul_en  = 1'b1;
        cmd.acc_clr = 1'b1;
        cmd.a_sel   = A_DIFF;
        cmd.b_sel   = B_K1000;
      end
      S_DR1: begin
        cmd.mul_en = 1'b1;
        cmd.chunk  = 1'b1;
        cmd.a_sel  = A_DIFF;
        cmd.b_sel  = B_K1000;
      end
      S_DR3: begin
        cmd.div_start = 1'b1;
        cmd.dvs_sel   = DVS_MS;
      end
      S_DER: cmd.deriv_ld = 1'b1;
      S_SUM0: begin
        cmd.mul_en  = 1'b1;
        cmd.acc_clr = 1'b1;
        cmd.a_sel   = A_ERR;
        cmd.b_sel   = B_GP;
      end
      S_SUM1: begin
        cmd.mul_en = 1'b1;
        cmd.chunk  = 1'b1;
        cmd.a_sel  = A_ERR;
        cmd.b_sel  = B_GP;
      end
      S_SUM2: begin
        cmd.mul_en = 1'b1;
        cmd.a_sel  = A_INTEG;
        cmd.b_sel  = B_GI;
      end
      S_SUM3: begin
        cmd.mul_en = 1'b1;
        cmd.chunk  = 1'b1;
        cmd.a_sel  = A_INTEG;
        cmd.b_sel  = B_GI;
      end
      S_SUM4: begin
        cmd.mul_en = 1'b1;
        cmd.a_sel  = A_DERIV;
        cmd.b_sel  = B_GD;
      end
      S_SUM5: begin
        cmd.mul_en = 1'b1;
        cmd.chunk  = 1'b1;
        cmd.a_sel  = A_DERIV;
        cmd.b_sel  = B_GD;
      end
      S_FIN:  cmd.fin_ld = fin_fire;
      default: ;
    endcase
  end

endmodule

[src/wsp_checker.sv]
// Port-level checker for the wheel speed loop and its bind to the top level.
`include "wheel_speed_pid_unit_defines.svh"

module wsp_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [wsp_pkg::S24_W-1:0] measured_speed,
  input logic signed [wsp_pkg::S24_W-1:0] control_value,
  input logic                             drive_forward,
  input logic [wsp_pkg::DUTY_W-1:0]       pwm_duty
);

  // A stalled result beat stays put.
  `WSP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(control_value) && $stable(measured_speed), "stalled result changed")

  // Only one tick is in work at a time.
  `WSP_ASSERT_NEXT(a_one_tick, clk, rst, in_valid && in_ready, !in_ready, "input taken while busy")

  // Direction follows the sign of the control value.
  `WSP_ASSERT_NOW(a_dir, clk, rst, out_valid, drive_forward == (!control_value[23] && (control_value != 24'sd0)), "direction bit disagrees with control value")

  // Small positive control values give their integer part as duty.
  `WSP_ASSERT_NOW(a_duty, clk, rst, out_valid && !control_value[23] && (control_value[22:16] == 7'd0), pwm_duty == control_value[15:8], "duty disagrees with control value")

endmodule

bind wheel_speed_pid_unit wsp_checker u_wsp_checker (.*);
